[sv/infix_to_postfix_converter_defines.svh]
// Assertion macros for the converter RTL.
// No dependencies; included by modules that carry assertions.
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define I2P_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define I2P_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/i2p_pkg.sv]
// Shared constants, types and functions of the infix to postfix converter.
// No dependencies.
package i2p_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  localparam logic [7:0] CH_END   = 8'h23;  // '#'
  localparam logic [7:0] CH_LPAR  = 8'h28;  // '('
  localparam logic [7:0] CH_RPAR  = 8'h29;  // ')'
  localparam logic [7:0] CH_TIMES = 8'h2A;  // '*'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_DIV   = 8'h2F;  // '/'

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_LPAR  = 3'd1;
  localparam logic [2:0] OP_PLUS  = 3'd2;
  localparam logic [2:0] OP_MINUS = 3'd3;
  localparam logic [2:0] OP_TIMES = 3'd4;
  localparam logic [2:0] OP_DIV   = 3'd5;

  localparam logic [2:0] CLS_OPERAND = 3'd0;
  localparam logic [2:0] CLS_LPAR    = 3'd1;
  localparam logic [2:0] CLS_RPAR    = 3'd2;
  localparam logic [2:0] CLS_OPER    = 3'd3;
  localparam logic [2:0] CLS_END     = 3'd4;

  localparam logic [1:0] KIND_SYMBOL    = 2'd0;
  localparam logic [1:0] KIND_END       = 2'd1;
  localparam logic [1:0] KIND_OVERFLOW  = 2'd2;
  localparam logic [1:0] KIND_UNMATCHED = 2'd3;

  typedef struct packed {
    logic [7:0] ch;
    logic [2:0] cls;
    logic [2:0] code;
  } cmd_t;

  function automatic logic [1:0] op_prio(input logic [2:0] code);
    case (code)
      OP_LPAR:          op_prio = 2'd1;
      OP_PLUS, OP_MINUS: op_prio = 2'd2;
      OP_TIMES, OP_DIV: op_prio = 2'd3;
      default:          op_prio = 2'd0;
    endcase
  endfunction

  function automatic logic [7:0] op_char(input logic [2:0] code);
    case (code)
      OP_LPAR:  op_char = CH_LPAR;
      OP_PLUS:  op_char = CH_PLUS;
      OP_MINUS: op_char = CH_MINUS;
      OP_TIMES: op_char = CH_TIMES;
      OP_DIV:   op_char = CH_DIV;
      default:  op_char = 8'd0;
    endcase
  endfunction

endpackage

[sv/infix_to_postfix_converter.sv]
// Infix to postfix converter top level: front classifier/queue and back stack engine.
// The first result of a request passes through the queue register, then the back end's output register.
// Each popped stack entry takes its own step of the back end, except the matching '(' of ')',
// which pops in the step that retires the request; output stalls hold it; a 2-entry queue decouples.
// Reset: synchronous active-low rst_n empties queue, stack and output register.
module infix_to_postfix_converter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_char
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic [1:0] out_tuser,  // [1:0] kind
  output logic       out_tlast
);
  import i2p_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  i2p_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  i2p_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[sv/i2p_front.sv]
// Front end: classifies input characters and queues them as commands.
// Depends on i2p_pkg.
module i2p_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // [7:0] in_char
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output i2p_pkg::cmd_t cmd
);
  import i2p_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] fill_r;
  cmd_t       cls_cmd;
  logic       wr, rd;

  always_comb begin
    cls_cmd.ch   = in_tdata;
    cls_cmd.cls  = CLS_OPERAND;
    cls_cmd.code = OP_NONE;
    unique case (in_tdata)
      CH_END:   cls_cmd.cls = CLS_END;
      CH_RPAR:  cls_cmd.cls = CLS_RPAR;
      CH_LPAR: begin
        cls_cmd.cls  = CLS_LPAR;
        cls_cmd.code = OP_LPAR;
      end
      CH_PLUS: begin
        cls_cmd.cls  = CLS_OPER;
        cls_cmd.code = OP_PLUS;
      end
      CH_MINUS: begin
        cls_cmd.cls  = CLS_OPER;
        cls_cmd.code = OP_MINUS;
      end
      CH_TIMES: begin
        cls_cmd.cls  = CLS_OPER;
        cls_cmd.code = OP_TIMES;
      end
      CH_DIV: begin
        cls_cmd.cls  = CLS_OPER;
        cls_cmd.code = OP_DIV;
      end
      default: cls_cmd.cls = CLS_OPERAND;
    endcase
  end

  assign in_tready = (fill_r != 2'd2);
  assign cmd_valid = (fill_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign wr        = in_tvalid && in_tready;
  assign rd        = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      if (wr && !rd) fill_r <= fill_r + 2'd1;
      else if (rd && !wr) fill_r <= fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) q_r[wp_r] <= cls_cmd;
  end

endmodule

[sv/i2p_back.sv]
// Back end: operator stack sequencer and output register.
// Depends on i2p_pkg and infix_to_postfix_converter_defines.svh.
`include "infix_to_postfix_converter_defines.svh"

module i2p_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  i2p_pkg::cmd_t cmd,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,  // [7:0] out_char
  output logic [1:0]    out_tuser,  // [1:0] kind
  output logic          out_tlast
);
  import i2p_pkg::*;

  // top of stack lives in top_r; stk_r holds the entries below it
  logic [2:0]       stk_r [STACK_DEPTH];
  logic [2:0]       top_r;
  logic [CNT_W-1:0] cnt_r;
  logic             out_valid_r, out_last_r;
  logic [7:0]       out_char_r;
  logic [1:0]       out_kind_r;

  logic [CNT_W-1:0] cnt_m1, cnt_m2;
  logic [2:0]       below;
  logic             empty, full, deep, emit_ok;
  logic             need_emit, done, pop, push, act;
  logic [7:0]       e_char;
  logic [1:0]       e_kind;
  logic             e_last;

  assign cnt_m1  = cnt_r - CNT_W'(1);
  assign cnt_m2  = cnt_r - CNT_W'(2);
  assign below   = stk_r[cnt_m2[IDX_W-1:0]];
  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CNT_W'(STACK_DEPTH));
  assign deep    = (cnt_r > CNT_W'(1));
  assign emit_ok = !out_valid_r || out_tready;

  always_comb begin
    need_emit = 1'b0;
    done      = 1'b0;
    pop       = 1'b0;
    push      = 1'b0;
    e_char    = 8'd0;
    e_kind    = KIND_SYMBOL;
    e_last    = 1'b0;
    unique case (cmd.cls)
      CLS_OPERAND: begin
        need_emit = 1'b1;
        e_char    = cmd.ch;
        e_last    = 1'b1;
        done      = 1'b1;
      end
      CLS_LPAR: begin
        done = 1'b1;
        if (full) begin
          need_emit = 1'b1;
          e_kind    = KIND_OVERFLOW;
          e_last    = 1'b1;
        end else begin
          push = 1'b1;
        end
      end
      CLS_OPER: begin
        if (!empty && top_r != OP_LPAR && op_prio(top_r) >= op_prio(cmd.code)) begin
          pop       = 1'b1;
          need_emit = 1'b1;
          e_char    = op_char(top_r);
          e_last    = !(deep && below != OP_LPAR && op_prio(below) >= op_prio(cmd.code));
        end else if (full) begin
          done      = 1'b1;
          need_emit = 1'b1;
          e_kind    = KIND_OVERFLOW;
          e_last    = 1'b1;
        end else begin
          done = 1'b1;
          push = 1'b1;
        end
      end
      CLS_RPAR: begin
        if (empty) begin
          done      = 1'b1;
          need_emit = 1'b1;
          e_kind    = KIND_UNMATCHED;
          e_last    = 1'b1;
        end else if (top_r == OP_LPAR) begin
          done = 1'b1;
          pop  = 1'b1;
        end else begin
          pop       = 1'b1;
          need_emit = 1'b1;
          e_char    = op_char(top_r);
          e_last    = deep && below == OP_LPAR;
        end
      end
      CLS_END: begin
        if (empty) begin
          done      = 1'b1;
          need_emit = 1'b1;
          e_kind    = KIND_END;
          e_last    = 1'b1;
        end else if (top_r == OP_LPAR) begin
          pop = 1'b1;
        end else begin
          pop       = 1'b1;
          need_emit = 1'b1;
          e_char    = op_char(top_r);
        end
      end
      default: done = 1'b1;
    endcase
  end

  assign act       = cmd_valid && (!need_emit || emit_ok);
  assign cmd_ready = act && done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (act && pop) cnt_r <= cnt_m1;
      else if (act && push) cnt_r <= cnt_r + CNT_W'(1);
      if (act && need_emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (act && pop) top_r <= below;
    if (act && push) begin
      top_r <= cmd.code;
      if (!empty) stk_r[cnt_m1[IDX_W-1:0]] <= top_r;
    end
    if (act && need_emit) begin
      out_char_r <= e_char;
      out_kind_r <= e_kind;
      out_last_r <= e_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  `I2P_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
  `I2P_ASSERT_NXT(a_end_clears, cmd_ready && cmd.cls == CLS_END, cnt_r == '0, "end left stack")
  `I2P_ASSERT_IMP(a_nonsym_zero, out_valid_r && out_kind_r != KIND_SYMBOL,
                  out_char_r == 8'd0 && out_last_r, "status record malformed")

endmodule
